// ===== rtl/pixel_readout_column_histogram_assert.svh =====
// ---------------------------------------------------------------------------
// Column histogram assertion macros
// Concurrent checks clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef PIXEL_READOUT_COLUMN_HISTOGRAM_ASSERT_SVH
`define PIXEL_READOUT_COLUMN_HISTOGRAM_ASSERT_SVH
`ifndef ASSERT_OFF
`define PRCH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PRCH_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PRCH_ASSERT(lbl, prop, msg)
`define PRCH_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/prch_pkg.sv =====
// ---------------------------------------------------------------------------
// Column histogram package
// Sizes, command and status codes, queue entry type and byte swap helper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package prch_pkg;

  localparam int NUM_COLUMNS = 72;
  localparam int COUNT_WIDTH = 32;
  localparam int CNT_W       = 13;
  localparam int COL_W       = 7;
  localparam int FRAME_W     = 32;
  localparam int HIT_W       = 32;
  localparam int ADDR_W      = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  localparam logic [CNT_W:0]       NUM_COLS_LIM = (CNT_W + 1)'(NUM_COLUMNS);
  localparam logic [COUNT_WIDTH-1:0] BIN_MAX    = {COUNT_WIDTH{1'b1}};
  localparam logic [FRAME_W-1:0]   FRAME_MAX    = {FRAME_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_UNSYNCED  = 3'd0,
    ST_HIT       = 3'd1,
    ST_NO_HIT    = 3'd2,
    ST_RANGE     = 3'd3,
    ST_DISCARDED = 3'd4,
    ST_READ      = 3'd5,
    ST_CLEARED   = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    OP_IMM,
    OP_HIT,
    OP_PEEK,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [ADDR_W-1:0]  addr;
    status_t            status;
    logic [COL_W-1:0]   column;
    logic [FRAME_W-1:0] frames;
  } entry_t;

  function automatic logic [31:0] swap_bytes(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

// ===== rtl/prch_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 72
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/prch_front.sv =====
// ---------------------------------------------------------------------------
// Column histogram front end
// Accepts commands, tracks sync, frame base and frame count, classifies work.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prch_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    command,
  input  logic [31:0]                   word,
  input  logic                          block_start,
  input  logic [prch_pkg::COL_W-1:0]    bin_index,
  input  logic                          q_full,
  output logic                          q_push,
  output prch_pkg::entry_t              q_entry
);

  logic                          synced, synced_next;
  logic                          discarding, discarding_next;
  logic [prch_pkg::CNT_W-1:0]    frame_base, frame_base_next;
  logic [prch_pkg::FRAME_W-1:0]  frames, frames_next, frames_inc;
  logic [31:0]                   swapped;
  logic [prch_pkg::CNT_W-1:0]    cnt, base_eff, diff;
  logic                          marker, ready_bit;
  logic                          has_result;
  logic                          accepted;
  prch_pkg::cmd_t                cmd;

  assign in_stall = q_full;
  assign accepted = in_valid && !q_full;
  assign q_push   = accepted && has_result;

  assign swapped    = prch_pkg::swap_bytes(word);
  assign cnt        = swapped[31:19];
  assign marker     = swapped[18];
  assign ready_bit  = swapped[17];
  assign cmd        = prch_pkg::cmd_t'(command);
  assign frames_inc = (frames == prch_pkg::FRAME_MAX) ? frames : frames + 1'b1;
  assign base_eff   = marker ? cnt : frame_base;
  assign diff       = cnt - base_eff;

  always_comb begin
    synced_next     = synced;
    discarding_next = discarding;
    frame_base_next = frame_base;
    frames_next     = frames;
    has_result      = 1'b1;
    q_entry.op      = prch_pkg::OP_IMM;
    q_entry.addr    = '0;
    q_entry.status  = prch_pkg::ST_UNSYNCED;
    q_entry.column  = '0;
    case (cmd)
      prch_pkg::CMD_DATA: begin
        // block start drops sync before the word is looked at
        synced_next     = synced && !block_start;
        discarding_next = discarding && !block_start;
        if (discarding_next) begin
          q_entry.status = prch_pkg::ST_DISCARDED;
        end else begin
          if (marker) begin
            synced_next     = 1'b1;
            frame_base_next = cnt;
            frames_next     = frames_inc;
          end
          if (!synced_next) begin
            q_entry.status = prch_pkg::ST_UNSYNCED;
          end else if ({1'b0, diff} >= prch_pkg::NUM_COLS_LIM) begin
            discarding_next = 1'b1;
            q_entry.status  = prch_pkg::ST_RANGE;
          end else begin
            q_entry.op     = ready_bit ? prch_pkg::OP_HIT : prch_pkg::OP_PEEK;
            q_entry.status = ready_bit ? prch_pkg::ST_HIT : prch_pkg::ST_NO_HIT;
            q_entry.column = diff[prch_pkg::COL_W-1:0];
            q_entry.addr   = diff[prch_pkg::ADDR_W-1:0];
          end
        end
      end
      prch_pkg::CMD_READ: begin
        q_entry.column = bin_index;
        if ((prch_pkg::CNT_W + 1)'(bin_index) >= prch_pkg::NUM_COLS_LIM) begin
          q_entry.status = prch_pkg::ST_RANGE;
        end else begin
          q_entry.op     = prch_pkg::OP_READ;
          q_entry.status = prch_pkg::ST_READ;
          q_entry.addr   = prch_pkg::ADDR_W'((prch_pkg::CNT_W)'(bin_index));
        end
      end
      prch_pkg::CMD_CLEAR: begin
        frames_next    = '0;
        q_entry.op     = prch_pkg::OP_CLEAR;
        q_entry.status = prch_pkg::ST_CLEARED;
      end
      default: begin
        // ignored command: drop it, no result
        has_result = 1'b0;
      end
    endcase
    q_entry.frames = frames_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      synced     <= 1'b0;
      discarding <= 1'b0;
      frames     <= '0;
    end else if (accepted) begin
      synced     <= synced_next;
      discarding <= discarding_next;
      frames     <= frames_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accepted) begin
      frame_base <= frame_base_next;
    end
  end

endmodule

// ===== rtl/prch_queue.sv =====
// ---------------------------------------------------------------------------
// Column histogram work queue
// Short FIFO of classified commands between the front end and the bin store.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prch_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  prch_pkg::entry_t entry_in,
  output logic             full,
  output logic             q_valid,
  output prch_pkg::entry_t q_entry,
  input  logic             pop
);

  prch_pkg::entry_t                  mem [prch_pkg::QUEUE_DEPTH];
  logic [prch_pkg::QUEUE_AW-1:0]     wr_ptr, rd_ptr;
  logic [prch_pkg::QUEUE_AW:0]       count;

  assign full    = count == (prch_pkg::QUEUE_AW + 1)'(prch_pkg::QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign q_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry_in;
    end
  end

endmodule

// ===== rtl/prch_back.sv =====
// ---------------------------------------------------------------------------
// Column histogram back end
// Reads, increments and clears the hit bins, and drives the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pixel_readout_column_histogram_assert.svh"

module prch_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  prch_pkg::entry_t               q_entry,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     status,
  output logic [prch_pkg::COL_W-1:0]     column,
  output logic [prch_pkg::HIT_W-1:0]     hit_count,
  output logic [prch_pkg::FRAME_W-1:0]   frame_count
);

  logic                                s1_valid;
  prch_pkg::entry_t                    s1_entry;
  logic                                s1_byp;
  logic [prch_pkg::COUNT_WIDTH-1:0]    s1_byp_data;
  logic                                s1_adv, out_adv, load;
  logic [prch_pkg::NUM_COLUMNS-1:0]    bin_valid;
  logic                                wr_en;
  logic [prch_pkg::COUNT_WIDTH-1:0]    rd_data, cur, inc, hits;
  prch_pkg::status_t                   out_status;

  assign out_adv = !out_valid || !out_stall;
  assign s1_adv  = s1_valid && out_adv;
  assign load    = q_valid && (!s1_valid || s1_adv);
  assign q_pop   = load;
  assign wr_en   = s1_adv && (s1_entry.op == prch_pkg::OP_HIT);

  prch_ram #(
    .WIDTH (prch_pkg::COUNT_WIDTH),
    .DEPTH (prch_pkg::NUM_COLUMNS)
  ) u_bins (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_entry.addr),
    .wr_data (inc),
    .rd_en   (load),
    .rd_addr (q_entry.addr),
    .rd_data (rd_data)
  );

  // a bin never written since the last clear reads as zero
  assign cur = !bin_valid[s1_entry.addr] ? '0 : (s1_byp ? s1_byp_data : rd_data);
  assign inc = (cur == prch_pkg::BIN_MAX) ? cur : cur + 1'b1;

  always_comb begin
    case (s1_entry.op)
      prch_pkg::OP_HIT:  hits = inc;
      prch_pkg::OP_PEEK: hits = cur;
      prch_pkg::OP_READ: hits = cur;
      default:           hits = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      bin_valid <= '0;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (out_adv) begin
        out_valid <= s1_valid;
      end
      if (s1_adv) begin
        if (s1_entry.op == prch_pkg::OP_CLEAR) begin
          bin_valid <= '0;
        end else if (s1_entry.op == prch_pkg::OP_HIT) begin
          bin_valid[s1_entry.addr] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_entry    <= q_entry;
      // catch the write that lands while this read is issued
      s1_byp      <= wr_en && (s1_entry.addr == q_entry.addr);
      s1_byp_data <= inc;
    end
    if (s1_adv) begin
      out_status  <= s1_entry.status;
      column      <= s1_entry.column;
      hit_count   <= prch_pkg::HIT_W'(hits);
      frame_count <= s1_entry.frames;
    end
  end

  assign status = out_status;

  `PRCH_ASSERT(a_s1_hold, s1_valid && out_valid && out_stall |=> s1_valid && $stable(s1_entry), "stage lost work under stall")
  `PRCH_ASSERT(a_clear_bins, s1_adv && s1_entry.op == prch_pkg::OP_CLEAR |=> bin_valid == '0, "bins not cleared")
  `PRCH_NEVER(a_hit_nonzero, out_valid && out_status == prch_pkg::ST_HIT && hit_count == '0, "counted hit reads zero")

endmodule

// ===== rtl/pixel_readout_column_histogram.sv =====
// A command is written into the work queue, then registered in stage s1 and then in the result register.
// Throughput: one command per cycle while the result side does not stall; the bin store reads at one port
// and writes back as the entry leaves stage s1, with a bypass for back-to-back hits on one column.
// Commands that return no result are accepted and produce nothing.
// Reset: rst is synchronous; it clears sync, discard, frame count, the queue
// and the per-bin valid flags, so all bins read zero at once with no sweep.
// ---------------------------------------------------------------------------
// Pixel readout column histogram
// Byte-swaps readout words, tracks frames and counts hits per column.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pixel_readout_column_histogram (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    command,
  input  logic [31:0]                   word,
  input  logic                          block_start,
  input  logic [prch_pkg::COL_W-1:0]    bin_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    status,
  output logic [prch_pkg::COL_W-1:0]    column,
  output logic [prch_pkg::HIT_W-1:0]    hit_count,
  output logic [prch_pkg::FRAME_W-1:0]  frame_count
);

  logic             q_full, q_push, q_valid, q_pop;
  prch_pkg::entry_t push_entry, head_entry;

  prch_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .word        (word),
    .block_start (block_start),
    .bin_index   (bin_index),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (push_entry)
  );

  prch_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .entry_in (push_entry),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_entry  (head_entry),
    .pop      (q_pop)
  );

  prch_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_entry     (head_entry),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .column      (column),
    .hit_count   (hit_count),
    .frame_count (frame_count)
  );

endmodule

// ===== test/pixel_readout_column_histogram_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Column histogram testbench
// Drives data, read, clear and ignored commands through the valid/stall
// handshake and predicts every readout. The prediction covers byte order,
// frame sync, column wrap, range discard and the hit bins. Both sides idle
// at random, and the result side holds off once for a long stretch.
// ---------------------------------------------------------------------------

module pixel_readout_column_histogram_test;

  import prch_pkg::*;

  localparam int          HOLD_CYCLES = 80;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int          DRAIN_CYCLES = 8;

  typedef struct {
    status_t      status;
    logic [6:0]   column;
    logic [31:0]  hits;
    logic [31:0]  frames;
  } readout_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         in_valid;
  logic         in_stall;
  logic [1:0]   command;
  logic [31:0]  word;
  logic         block_start;
  logic [6:0]   bin_index;
  logic         out_valid;
  logic         out_stall;
  logic [2:0]   status;
  logic [6:0]   column;
  logic [31:0]  hit_count;
  logic [31:0]  frame_count;

  // predicted histogram state
  logic [31:0]  bin_hits [NUM_COLUMNS];
  logic [31:0]  frames_total;
  logic [12:0]  base_count;
  logic         in_sync;
  logic         dropping;

  readout_t     expected_readouts[$];
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;
  bit           sender_gaps = 1'b0;
  bit           receiver_gaps = 1'b0;
  bit           hold_request = 1'b0;

  always #5 clk = ~clk;

  pixel_readout_column_histogram i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .word        (word),
    .block_start (block_start),
    .bin_index   (bin_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .column      (column),
    .hit_count   (hit_count),
    .frame_count (frame_count)
  );

  function automatic logic [31:0] byte_reverse(input logic [31:0] v);
    logic [31:0] r;
    for (int b = 0; b < 4; b++) r[8*b +: 8] = v[8*(3-b) +: 8];
    return r;
  endfunction

  // build a big-endian readout word; time and address bits are random
  function automatic logic [31:0] make_word(input logic [12:0] cnt, input logic marker,
                                            input logic ready);
    return byte_reverse({cnt, marker, ready, 10'($urandom), 7'($urandom)});
  endfunction

  task automatic histogram_predict(input cmd_t cmd, input logic [31:0] raw,
                                   input logic bs, input logic [6:0] idx);
    logic [31:0] v;
    logic [12:0] cnt;
    logic [12:0] col;
    readout_t    r;
    v = byte_reverse(raw);
    cnt = v[31:19];
    r.status = ST_UNSYNCED;
    r.column = '0;
    r.hits = '0;
    case (cmd)
      CMD_DATA: begin
        if (bs) begin
          in_sync = 1'b0;
          dropping = 1'b0;
        end
        if (dropping) begin
          r.status = ST_DISCARDED;
        end else begin
          if (v[18]) begin
            in_sync = 1'b1;
            base_count = cnt;
            if (frames_total != '1) frames_total++;
          end
          if (in_sync) begin
            col = cnt - base_count;
            if (col >= 13'(NUM_COLUMNS)) begin
              dropping = 1'b1;
              r.status = ST_RANGE;
            end else begin
              if (v[17]) begin
                if (bin_hits[col[6:0]] != '1) bin_hits[col[6:0]]++;
                r.status = ST_HIT;
              end else begin
                r.status = ST_NO_HIT;
              end
              r.column = col[6:0];
              r.hits = bin_hits[col[6:0]];
            end
          end
        end
      end
      CMD_READ: begin
        r.column = idx;
        if (idx >= 7'(NUM_COLUMNS)) begin
          r.status = ST_RANGE;
        end else begin
          r.status = ST_READ;
          r.hits = bin_hits[idx];
        end
      end
      CMD_CLEAR: begin
        foreach (bin_hits[i]) bin_hits[i] = '0;
        frames_total = '0;
        r.status = ST_CLEARED;
      end
      default: return;
    endcase
    r.frames = frames_total;
    expected_readouts.push_back(r);
  endtask

  // called at a rising edge; returns at the edge where the transfer happens
  task automatic send_item(input cmd_t cmd, input logic [31:0] w, input logic bs,
                           input logic [6:0] idx);
    bit taken;
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    word <= w;
    block_start <= bs;
    bin_index <= idx;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    histogram_predict(cmd, w, bs, idx);
  endtask

  task automatic test_unsynced();
    send_item(CMD_READ, '0, 1'b0, 7'd0);
    send_item(CMD_READ, '1, 1'b1, 7'd127);
    send_item(CMD_DATA, make_word(13'd5, 1'b0, 1'b1), 1'b0, 7'd0);
    send_item(CMD_NOP, '1, 1'b1, 7'd3);
    send_item(CMD_DATA, make_word(13'h1fff, 1'b0, 1'b1), 1'b1, 7'd127);
  endtask

  // base near the top of the counter so columns wrap
  task automatic test_frame_hits();
    send_item(CMD_DATA, make_word(13'd8190, 1'b1, 1'b1), 1'b1, 7'd0);
    send_item(CMD_DATA, make_word(13'd8191, 1'b0, 1'b1), 1'b0, 7'd0);
    send_item(CMD_DATA, make_word(13'd69, 1'b0, 1'b1), 1'b0, 7'd0);
    send_item(CMD_DATA, make_word(13'd69, 1'b0, 1'b0), 1'b0, 7'd0);
    send_item(CMD_DATA, make_word(13'd8190, 1'b0, 1'b1), 1'b0, 7'd0);
    send_item(CMD_READ, '0, 1'b0, 7'd71);
    send_item(CMD_READ, '0, 1'b0, 7'd0);
    send_item(CMD_READ, '0, 1'b0, 7'd72);
  endtask

  task automatic test_discard();
    send_item(CMD_DATA, make_word(13'd70, 1'b0, 1'b1), 1'b0, 7'd0);
    send_item(CMD_DATA, make_word(13'd100, 1'b1, 1'b1), 1'b0, 7'd0);
    send_item(CMD_DATA, make_word(13'd8190, 1'b0, 1'b1), 1'b0, 7'd0);
    send_item(CMD_DATA, make_word(13'd8190, 1'b0, 1'b1), 1'b1, 7'd0);
    send_item(CMD_DATA, make_word(13'd0, 1'b1, 1'b1), 1'b1, 7'd0);
    send_item(CMD_CLEAR, '1, 1'b1, 7'd127);
    send_item(CMD_READ, '0, 1'b0, 7'd0);
    send_item(CMD_DATA, make_word(13'd5, 1'b0, 1'b1), 1'b0, 7'd0);
    send_item(CMD_NOP, '0, 1'b0, 7'd0);
  endtask

  // blocks that mostly open with a frame marker, then words at chosen column offsets
  task automatic test_frame_stream(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned off;
    logic [12:0] base;
    logic        mark;
    sent = 0;
    while (sent < n_items) begin
      base = 13'($urandom);
      send_item(CMD_DATA, make_word(base, $urandom_range(0, 9) != 0, 1'($urandom)),
                1'b1, 7'($urandom));
      sent++;
      repeat ($urandom_range(1, 16)) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          send_item(CMD_READ, $urandom, 1'b0, 7'($urandom_range(0, 79)));
          sent++;
        end else if (pick < 7) begin
          send_item(CMD_CLEAR, $urandom, 1'b0, 7'($urandom));
          sent++;
        end else if (pick < 8) begin
          send_item(CMD_NOP, $urandom, 1'($urandom), 7'($urandom));
        end else begin
          if (pick < 12) off = $urandom_range(NUM_COLUMNS, 8191);
          else if (pick < 60) off = $urandom_range(0, 7);
          else off = $urandom_range(0, NUM_COLUMNS - 1);
          mark = (pick >= 96);
          send_item(CMD_DATA, make_word(13'(base + off), mark, $urandom_range(0, 3) != 0),
                    1'b0, 7'($urandom));
          if (mark) base = 13'(base + off);
          sent++;
        end
      end
    end
  endtask

  task automatic test_noise(input int unsigned n_items);
    int unsigned sent;
    cmd_t        cmd;
    sent = 0;
    while (sent < n_items) begin
      cmd = cmd_t'($urandom_range(0, 3));
      send_item(cmd, $urandom, $urandom_range(0, 7) == 0, 7'($urandom));
      if (cmd != CMD_NOP) sent++;
    end
  endtask

  // keep offering while the result side holds off, so the input stalls
  task automatic test_backpressure();
    bit gaps;
    gaps = sender_gaps;
    sender_gaps = 1'b0;
    hold_request = 1'b1;
    test_frame_stream(40);
    sender_gaps = gaps;
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    command <= CMD_NOP;
    word <= '0;
    block_start <= 1'b0;
    bin_index <= '0;
    foreach (bin_hits[i]) bin_hits[i] = '0;
    frames_total = '0;
    base_count = '0;
    in_sync = 1'b0;
    dropping = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unsynced();
    test_frame_hits();
    test_discard();
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    test_frame_stream(450);
    test_noise(200);
    test_backpressure();
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    test_frame_stream(100);
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    test_noise(100);
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    test_frame_stream(100);
    in_valid <= 1'b0;

    while (expected_readouts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_readouts.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // result side: short random holds, and one long hold on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // signals settle between edges, so judge the coming transfer at the falling edge
  always @(negedge clk) begin : check_readout
    readout_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_readouts.size() == 0) begin
        $error("unexpected readout: status %0d column %0d", status, column);
        mismatches++;
      end else begin
        want = expected_readouts.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          mismatches++;
        end
        if (column !== want.column) begin
          $error("column: expected %0d, actual %0d", want.column, column);
          mismatches++;
        end
        if (hit_count !== want.hits) begin
          $error("hit_count: expected %0d, actual %0d", want.hits, hit_count);
          mismatches++;
        end
        if (frame_count !== want.frames) begin
          $error("frame_count: expected %0d, actual %0d", want.frames, frame_count);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
